FILE: src/panel_reply_frame_parser_assert.svh
// Assertion macros for the panel reply frame parser.
// Used at the end of the top level; relies on clk and rst_n in the including module.
`ifndef PANEL_REPLY_FRAME_PARSER_ASSERT_SVH
`define PANEL_REPLY_FRAME_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PRF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");
`else
`define PRF_ASSERT_IMPLIES(label, ante, cons)
`define PRF_ASSERT_ALWAYS(label, cond)
`endif
`endif

FILE: src/prf_pkg.sv
// Shared types, constants and the command length table of the reply frame parser.
// No dependencies.
`default_nettype none
package prf_pkg;

    localparam int STORE_DEPTH = 9;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int POS_W = 4;
    localparam int LEN_W = 3;

    localparam logic [7:0] SYNC_REPLY = 8'h5A;
    localparam logic [7:0] SYNC_RAWIR = 8'h55;
    localparam logic [7:0] FLASH_MARK = 8'hFF;

    localparam logic [7:0] CODE_F2 = 8'hF2;
    localparam logic [7:0] CODE_F1 = 8'hF1;
    localparam logic [7:0] CODE_12 = 8'h12;
    localparam logic [7:0] CODE_00 = 8'h00;
    localparam logic [7:0] CODE_F3 = 8'hF3;
    localparam logic [7:0] CODE_0F = 8'h0F;
    localparam logic [7:0] CODE_11 = 8'h11;
    localparam logic [7:0] CODE_0B = 8'h0B;
    localparam logic [7:0] CODE_0E = 8'h0E;

    localparam logic [LEN_W-1:0] RAWIR_LEN = 3'd2;

    // One slot of the output row.
    typedef struct packed {
        logic             vld;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } cell_t;

    // Frame hand-off from the capture side to the output row.
    typedef struct packed {
        logic        fire;
        logic        kind;
        logic [31:0] time_stamp;
    } load_t;

    function automatic logic [LEN_W-1:0] length_of_code(input logic [7:0] code);
        logic [LEN_W-1:0] len;
        case (code)
            CODE_F2, CODE_F1, CODE_12:          len = 3'd4;
            CODE_00, CODE_F3, CODE_0F, CODE_11: len = 3'd2;
            CODE_0B, CODE_0E:                   len = 3'd7;
            default:                            len = 3'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: src/prf_cell.sv
// One slot of the output shift row: parallel load from the capture side, or
// take the neighbor's contents when the head is consumed. Uses prf_pkg.
`default_nettype none
module prf_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  wire                 shift,
    input  prf_pkg::cell_t      load_cell,
    input  prf_pkg::cell_t      from_next,
    output prf_pkg::cell_t      slot
);
    import prf_pkg::*;

    logic                 vld_reg;
    logic                 vld_next;
    logic [7:0]           data_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 last_reg;
    cell_t                pay_next;

    always_comb
    begin
        vld_next = vld_reg;
        pay_next = '{vld: vld_reg, data: data_reg, pos: pos_reg, last: last_reg};
        if (load)
        begin
            vld_next = load_cell.vld;
            pay_next = load_cell;
        end
        else if (shift)
        begin
            vld_next = from_next.vld;
            pay_next = from_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= pay_next.data;
        pos_reg  <= pay_next.pos;
        last_reg <= pay_next.last;
    end

    assign slot = '{vld: vld_reg, data: data_reg, pos: pos_reg, last: last_reg};
endmodule
`default_nettype wire

FILE: src/prf_capture.sv
// Capture side of the reply frame parser: sync hunt, command length lookup,
// frame store, and the parallel load image for the output row. Uses prf_pkg.
`default_nettype none
module prf_capture (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  wire  [7:0]           rx_byte,
    input  wire  [31:0]          arrival_time,
    output logic                 might_finish,
    output logic [prf_pkg::POS_W-1:0] position,
    output prf_pkg::load_t       ld,
    output prf_pkg::cell_t       ld_cells [prf_pkg::STORE_DEPTH]
);
    import prf_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [LEN_W-1:0] plen_reg;
    logic [LEN_W-1:0] plen_next;
    logic [31:0]      start_reg;
    logic [31:0]      start_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    logic [LEN_W-1:0] code_len;
    logic [POS_W-1:0] end_pos;
    logic             body_end;
    logic             is_sync;
    logic             done;
    logic             marker;
    logic [POS_W-1:0] count;

    assign code_len = (store_reg[0] == SYNC_RAWIR) ? RAWIR_LEN : length_of_code(rx_byte);
    assign end_pos  = POS_W'(plen_reg) + POS_W'(1);
    assign body_end = (pos_reg >= end_pos) || (pos_reg >= POS_W'(STORE_DEPTH - 1));
    assign is_sync  = (rx_byte == SYNC_REPLY) || (rx_byte == SYNC_RAWIR);

    // Whether some byte could complete a result in the current state.
    always_comb
    begin
        if (pos_reg == '0)
            might_finish = 1'b1;
        else if (pos_reg == POS_W'(1))
            might_finish = (store_reg[0] != SYNC_RAWIR);
        else
            might_finish = body_end;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        plen_next  = plen_reg;
        start_next = start_reg;
        done       = 1'b0;
        marker     = 1'b0;
        count      = POS_W'(2) + POS_W'(plen_reg);
        if (pos_reg == '0)
        begin
            if (is_sync)
            begin
                pos_next   = POS_W'(1);
                start_next = arrival_time;
            end
            else if (rx_byte == FLASH_MARK)
            begin
                done   = 1'b1;
                marker = 1'b1;
                count  = POS_W'(1);
            end
        end
        else if (pos_reg == POS_W'(1))
        begin
            plen_next = code_len;
            count     = POS_W'(2);
            if (code_len == '0)
            begin
                done     = 1'b1;
                pos_next = '0;
            end
            else
            begin
                pos_next = POS_W'(2);
            end
        end
        else
        begin
            if (body_end)
            begin
                done     = 1'b1;
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            plen_reg  <= '0;
            start_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            plen_reg  <= plen_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < POS_W'(STORE_DEPTH)))
            store_reg[pos_reg[IDX_W-1:0]] <= rx_byte;
    end

    // The completing byte is not in the store yet; it goes straight to its slot.
    always_comb
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            ld_cells[k].vld  = (POS_W'(k) < count);
            ld_cells[k].data = (pos_reg == POS_W'(k)) ? rx_byte : store_reg[k];
            ld_cells[k].pos  = POS_W'(k);
            ld_cells[k].last = (POS_W'(k + 1) == count);
        end
    end

    assign ld.fire       = accept && done;
    assign ld.kind       = marker;
    assign ld.time_stamp = marker ? arrival_time : start_reg;
    assign position      = pos_reg;
endmodule
`default_nettype wire

FILE: src/panel_reply_frame_parser.sv
// Top level of the panel reply frame parser: capture side plus a row of
// output cells. Uses prf_pkg, prf_capture, prf_cell and the assertion header.
`default_nettype none
// The parser takes one received byte per transaction, each with a time stamp,
// and cuts the stream into front-panel reply frames. While idle it drops
// all bytes except 0xFF and the sync bytes 0x5A (reply frame) and 0x55
// (raw IR frame); a sync byte opens a frame and its time stamp becomes the
// frame time. A 0xFF while idle yields a single flash-mode marker
// transaction (kind 1, last 1). A raw IR frame carries two payload bytes
// after the command byte; a reply frame carries 4, 2, 7 or 0 payload bytes
// depending on the command code. Once a frame is complete, its 2 to 9
// bytes leave in order, one output transaction per byte, sync byte first,
// with position, frame time and a last flag on the final byte. There is no
// timeout. A complete frame is loaded in parallel into a row of nine output
// cells that shift toward the output port, so the next frame is gathered
// while the previous one drains. The input accepts one byte per cycle; it
// holds off only when an incoming byte could complete a frame (or be a
// flash marker) while the output row still holds bytes other than a last
// one that is leaving in that same cycle.
module panel_reply_frame_parser (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  rx_byte,
    input  wire  [31:0] arrival_time,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        kind,
    output logic [7:0]  frame_byte,
    output logic [3:0]  byte_position,
    output logic [31:0] frame_time,
    output logic        last
);
    import prf_pkg::*;

    logic             accept;
    logic             might_finish;
    logic [POS_W-1:0] cap_pos;
    load_t            ld;
    cell_t            ld_cells [STORE_DEPTH];
    cell_t            cells    [STORE_DEPTH];
    logic             head_take;
    logic             row_free;
    logic             kind_reg;
    logic             kind_next;
    logic [31:0]      time_reg;
    logic [31:0]      time_next;

    // The row can take a new frame when it is empty or its final byte leaves now.
    assign head_take = cells[0].vld && out_ready;
    assign row_free  = !cells[0].vld || (cells[0].last && out_ready);
    assign in_ready  = row_free || !might_finish;
    assign accept    = in_valid && in_ready;

    prf_capture u_capture (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .arrival_time (arrival_time),
        .might_finish (might_finish),
        .position     (cap_pos),
        .ld           (ld),
        .ld_cells     (ld_cells)
    );

    // Output row: cell zero is the head; each cell takes its upper neighbor's
    // contents when the head transaction completes.
    for (genvar k = 0; k < STORE_DEPTH; k++)
    begin : g_cell
        cell_t upper;
        if (k == STORE_DEPTH - 1)
        begin : g_end
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cells[k + 1];
        end
        prf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (ld.fire),
            .shift     (head_take),
            .load_cell (ld_cells[k]),
            .from_next (upper),
            .slot      (cells[k])
        );
    end

    assign kind_next = ld.fire ? ld.kind : kind_reg;
    assign time_next = ld.fire ? ld.time_stamp : time_reg;

    // Frame attributes shared by every byte of the frame in the row.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        time_reg <= time_next;
    end

    assign out_valid     = cells[0].vld;
    assign kind          = kind_reg;
    assign frame_byte    = cells[0].data;
    assign byte_position = cells[0].pos;
    assign frame_time    = time_reg;
    assign last          = cells[0].last;

    `include "panel_reply_frame_parser_assert.svh"

    // A valid second cell has a valid head in front of it, and a frame's last
    // byte at the head is never followed by more bytes of the same run.
    `PRF_ASSERT_IMPLIES(a_row_contiguous, cells[1].vld, cells[0].vld && !cells[0].last)
    // A frame is only loaded when the row is free to take it.
    `PRF_ASSERT_IMPLIES(a_load_when_free, ld.fire, row_free)
    // The capture position never runs past the last store slot.
    `PRF_ASSERT_ALWAYS(a_pos_range, cap_pos <= POS_W'(STORE_DEPTH - 1))
    // A flash marker is a single transaction at position zero.
    `PRF_ASSERT_IMPLIES(a_marker_single, out_valid && kind, last && (byte_position == '0))
endmodule
`default_nettype wire
